>>> hdl/qspg_pkg.sv
// ----------------------------------------------------------------------------
// qspg_pkg
// Shared types and constants of the queued step pulse generator.
// ----------------------------------------------------------------------------
package qspg_pkg;

  localparam int KIND_W     = 2;
  localparam int AXIS_IN_W  = 2;
  localparam int INTERVAL_W = 31;
  localparam int COUNT_W    = 16;
  localparam int CHANGE_W   = 32;
  localparam int TIME_W     = 32;
  localparam int QDEPTH_W   = 6;
  localparam int TOTAL_W    = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVICE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 31'h7FFF_FFFF;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MIN = 31'd1;

  typedef struct packed {
    logic [INTERVAL_W-1:0]      interval;
    logic [COUNT_W-1:0]         count;
    logic signed [CHANGE_W-1:0] change;
  } chunk_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

>>> hdl/queued_step_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// queued_step_pulse_generator_unit
// Per-axis step chunk rings with push, service and clear commands.
// ----------------------------------------------------------------------------
// Each input word is captured at its accepting edge, where the chunk ring memory
// read is also registered, and executed at a later edge, where its result word
// is registered. No further word is accepted until the captured one has been
// executed. A new word is accepted while the previous result still waits at
// the output, but it is executed only once that result has been taken, so an
// output stall delays its execution.
// Ring contents are undefined until written and need no clearing pass after
// reset.
module queued_step_pulse_generator_unit
  import qspg_pkg::*;
#(
  parameter int AXES       = 2,
  parameter int RING_SLOTS = 64
)(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [AXIS_IN_W-1:0]       axis,
  input  logic [INTERVAL_W-1:0]      first_interval,
  input  logic [COUNT_W-1:0]         step_number,
  input  logic signed [CHANGE_W-1:0] interval_change,
  input  logic [TIME_W-1:0]          now_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       accepted,
  output logic                       chunk_loaded,
  output logic                       step_pulse,
  output logic                       chunk_finished,
  output logic [QDEPTH_W-1:0]        queue_depth,
  output logic                       axis_active,
  output logic signed [TOTAL_W-1:0]  step_total
);

  ctl_t ctl;

  qspg_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  qspg_datapath #(
    .AXES       (AXES),
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .kind            (kind),
    .axis            (axis),
    .first_interval  (first_interval),
    .step_number     (step_number),
    .interval_change (interval_change),
    .now_us          (now_us),
    .accepted        (accepted),
    .chunk_loaded    (chunk_loaded),
    .step_pulse      (step_pulse),
    .chunk_finished  (chunk_finished),
    .queue_depth     (queue_depth),
    .axis_active     (axis_active),
    .step_total      (step_total)
  );

`ifndef SYNTHESIS
  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word was in flight");

  a_finish_needs_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chunk_finished) |-> (step_pulse && !axis_active))
    else $error("chunk finished without a step or axis still active");

  a_load_no_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chunk_loaded) |-> (accepted && axis_active && !step_pulse))
    else $error("chunk load reported with inconsistent status");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (!chunk_loaded && !step_pulse))
    else $error("rejected word changed axis state");
`endif

endmodule

>>> hdl/qspg_controller.sv
// ----------------------------------------------------------------------------
// qspg_controller
// Sequences one word at a time: capture on the input side, execute once the
// result register is free, and hold the output valid until it is taken.
// ----------------------------------------------------------------------------
module qspg_controller
  import qspg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    ctl.capture = in_valid && (state == ST_IDLE);
    ctl.execute = (state == ST_EXEC) && (!out_valid || !out_stall);
    in_stall    = !(state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.capture) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ctl.execute) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (ctl.execute) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hdl/qspg_datapath.sv
// ----------------------------------------------------------------------------
// qspg_datapath
// Chunk ring memory, per-axis ring indices and live step registers, interval
// arithmetic and the registered result word.
// ----------------------------------------------------------------------------
module qspg_datapath
  import qspg_pkg::*;
#(
  parameter int AXES       = 2,
  parameter int RING_SLOTS = 64
)(
  input  logic                         clk,
  input  logic                         rst,
  input  ctl_t                         ctl,
  input  logic [KIND_W-1:0]            kind,
  input  logic [AXIS_IN_W-1:0]         axis,
  input  logic [INTERVAL_W-1:0]        first_interval,
  input  logic [COUNT_W-1:0]           step_number,
  input  logic signed [CHANGE_W-1:0]   interval_change,
  input  logic [TIME_W-1:0]            now_us,
  output logic                         accepted,
  output logic                         chunk_loaded,
  output logic                         step_pulse,
  output logic                         chunk_finished,
  output logic [QDEPTH_W-1:0]          queue_depth,
  output logic                         axis_active,
  output logic signed [TOTAL_W-1:0]    step_total
);

  localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int SLOT_W    = $clog2(RING_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int MEM_DEPTH = AXES * RING_SLOTS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W     = INTERVAL_W + 3;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
    return (i == SLOT_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  chunk_t ring_mem [MEM_DEPTH];
  chunk_t rd_chunk;

  logic [SLOT_W-1:0]          write_index    [AXES];
  logic [SLOT_W-1:0]          read_index     [AXES];
  logic                       running        [AXES];
  logic [INTERVAL_W-1:0]      live_interval  [AXES];
  logic [COUNT_W-1:0]         live_count     [AXES];
  logic signed [CHANGE_W-1:0] live_change    [AXES];
  logic [TIME_W-1:0]          step_stamp     [AXES];
  logic [TOTAL_W-1:0]         steps_done     [AXES];

  logic [KIND_W-1:0] item_kind;
  logic              item_ok;
  logic [AXIS_W-1:0] item_idx;
  chunk_t            item_chunk;
  logic [TIME_W-1:0] item_now;

  logic              in_ok;
  logic [AXIS_W-1:0] in_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic [SLOT_W-1:0]          w_cur;
  logic [SLOT_W-1:0]          r_cur;
  logic [SLOT_W-1:0]          w_inc;
  logic [SLOT_W-1:0]          r_inc;
  logic [TIME_W-1:0]          elapsed;
  logic                       due;
  logic [COUNT_W-1:0]         count_dec;
  logic signed [SUM_W-1:0]    interval_sum;
  logic [INTERVAL_W-1:0]      interval_step;
  logic [CNT_W-1:0]           depth_calc;

  logic                       acc_n;
  logic                       loaded_n;
  logic                       pulse_n;
  logic                       finished_n;
  logic                       mem_we;
  logic [SLOT_W-1:0]          write_index_next;
  logic [SLOT_W-1:0]          read_index_next;
  logic                       running_next;
  logic [INTERVAL_W-1:0]      live_interval_next;
  logic [COUNT_W-1:0]         live_count_next;
  logic signed [CHANGE_W-1:0] live_change_next;
  logic [TIME_W-1:0]          step_stamp_next;
  logic [TOTAL_W-1:0]         steps_done_next;

  always_comb begin
    in_ok   = (axis < AXES);
    in_idx  = in_ok ? AXIS_W'(axis) : '0;
    rd_addr = ADDR_W'(in_idx * RING_SLOTS) + ADDR_W'(read_index[in_idx]);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_kind           <= kind;
      item_ok             <= in_ok;
      item_idx            <= in_idx;
      item_chunk.interval <= first_interval;
      item_chunk.count    <= step_number;
      item_chunk.change   <= interval_change;
      item_now            <= now_us;
      rd_chunk            <= ring_mem[rd_addr];
    end
    if (mem_we) begin
      ring_mem[wr_addr] <= item_chunk;
    end
  end

  always_comb begin
    w_cur     = write_index[item_idx];
    r_cur     = read_index[item_idx];
    w_inc     = ring_next(w_cur);
    r_inc     = ring_next(r_cur);
    wr_addr   = ADDR_W'(item_idx * RING_SLOTS) + ADDR_W'(w_cur);
    elapsed   = item_now - step_stamp[item_idx];
    due       = !elapsed[TIME_W-1] && (elapsed >= {1'b0, live_interval[item_idx]});
    count_dec = (live_count[item_idx] != '0) ? live_count[item_idx] - 1'b1
                                              : live_count[item_idx];
    interval_sum = $signed({3'b000, live_interval[item_idx]})
                 + SUM_W'(live_change[item_idx]);
    if (interval_sum < $signed(SUM_W'(INTERVAL_MIN))) begin
      interval_step = INTERVAL_MIN;
    end else if (interval_sum > $signed(SUM_W'(INTERVAL_MAX))) begin
      interval_step = INTERVAL_MAX;
    end else begin
      interval_step = interval_sum[INTERVAL_W-1:0];
    end
  end

  always_comb begin
    acc_n               = 1'b0;
    loaded_n            = 1'b0;
    pulse_n             = 1'b0;
    finished_n          = 1'b0;
    mem_we              = 1'b0;
    write_index_next    = w_cur;
    read_index_next     = r_cur;
    running_next        = running[item_idx];
    live_interval_next  = live_interval[item_idx];
    live_count_next     = live_count[item_idx];
    live_change_next    = live_change[item_idx];
    step_stamp_next     = step_stamp[item_idx];
    steps_done_next     = steps_done[item_idx];
    if (item_ok) begin
      case (item_kind)
        KIND_PUSH: begin
          if (w_inc != r_cur) begin
            acc_n            = 1'b1;
            mem_we           = ctl.execute;
            write_index_next = w_inc;
          end
        end
        KIND_SERVICE: begin
          acc_n = 1'b1;
          if (!running[item_idx]) begin
            if (r_cur != w_cur) begin
              loaded_n            = 1'b1;
              live_interval_next  = rd_chunk.interval;
              live_count_next     = rd_chunk.count;
              live_change_next    = rd_chunk.change;
              read_index_next     = r_inc;
              running_next        = 1'b1;
              step_stamp_next     = item_now;
            end
          end else if (due) begin
            pulse_n             = 1'b1;
            step_stamp_next     = item_now;
            steps_done_next     = steps_done[item_idx] + 1'b1;
            live_count_next     = count_dec;
            live_interval_next  = interval_step;
            if (count_dec == '0) begin
              running_next = 1'b0;
              finished_n   = 1'b1;
            end
          end
        end
        KIND_CLEAR: begin
          acc_n           = 1'b1;
          read_index_next = w_cur;
          running_next    = 1'b0;
        end
        default: begin
          acc_n = 1'b0;
        end
      endcase
    end
    if (write_index_next >= read_index_next) begin
      depth_calc = {1'b0, write_index_next} - {1'b0, read_index_next};
    end else begin
      depth_calc = CNT_W'(RING_SLOTS) - {1'b0, read_index_next} + {1'b0, write_index_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        write_index[a]    <= '0;
        read_index[a]     <= '0;
        running[a]        <= 1'b0;
        live_interval[a]  <= '0;
        live_count[a]     <= '0;
        live_change[a]    <= '0;
        step_stamp[a]     <= '0;
        steps_done[a]     <= '0;
      end
    end else if (ctl.execute && item_ok) begin
      write_index[item_idx]    <= write_index_next;
      read_index[item_idx]     <= read_index_next;
      running[item_idx]        <= running_next;
      live_interval[item_idx]  <= live_interval_next;
      live_count[item_idx]     <= live_count_next;
      live_change[item_idx]    <= live_change_next;
      step_stamp[item_idx]     <= step_stamp_next;
      steps_done[item_idx]     <= steps_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      accepted       <= acc_n;
      chunk_loaded   <= loaded_n;
      step_pulse     <= pulse_n;
      chunk_finished <= finished_n;
      queue_depth    <= item_ok ? QDEPTH_W'(depth_calc) : '0;
      axis_active    <= item_ok && running_next;
      step_total     <= item_ok ? $signed(steps_done_next) : '0;
    end
  end

endmodule
